// ===== rtl/core/rgbfx_pkg.sv =====
// rgbfx_pkg: shared constants, codes, control types and constant functions
// for the RGB LED effect generator. No dependencies.
// The sine ramp ROM contents are computed by the functions here at elaboration time.

package rgbfx_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_BASE_RED    = 3'd0;
  localparam logic [2:0] REG_BASE_GREEN  = 3'd1;
  localparam logic [2:0] REG_BASE_BLUE   = 3'd2;
  localparam logic [2:0] REG_EFFECT_MODE = 3'd3;
  localparam logic [2:0] REG_SPEED       = 3'd4;
  localparam logic [2:0] REG_BRIGHTNESS  = 3'd5;

  // Effect modes
  localparam logic [1:0] EFX_STATIC  = 2'd0;
  localparam logic [1:0] EFX_BREATHE = 2'd1;
  localparam logic [1:0] EFX_CYCLE   = 2'd2;
  localparam logic [1:0] EFX_BLANK   = 2'd3;

  // Speed codes (code three runs as fast)
  localparam logic [1:0] SPD_SLOW   = 2'd0;
  localparam logic [1:0] SPD_MEDIUM = 2'd1;
  localparam logic [1:0] SPD_FAST   = 2'd2;

  // Brightness levels
  localparam logic [1:0] LVL_15  = 2'd0;
  localparam logic [1:0] LVL_33  = 2'd1;
  localparam logic [1:0] LVL_66  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0] RST_BASE       = 8'd255;
  localparam logic [1:0] RST_SPEED      = SPD_MEDIUM;
  localparam logic [1:0] RST_BRIGHTNESS = 2'd3;

  // Q1.15 brightness scales
  localparam logic [15:0] SCALE_15  = 16'd4915;
  localparam logic [15:0] SCALE_33  = 16'd10813;
  localparam logic [15:0] SCALE_66  = 16'd21627;
  localparam logic [15:0] SCALE_100 = 16'd32768;
  localparam longint unsigned Q15_ONE = 32768;

  // Breathe ramp lengths and hold time
  localparam int unsigned RAMP_SLOW   = 80;
  localparam int unsigned RAMP_MED    = 50;
  localparam int unsigned RAMP_FAST   = 28;
  localparam int unsigned HOLD_FRAMES = 12;

  // Hue walk, tenths of a degree
  localparam int unsigned HUE_SECTOR = 600;
  localparam int unsigned HUE_SECTORS = 6;
  localparam int unsigned HUE_STEP_SLOW = 4;
  localparam int unsigned HUE_STEP_MED  = 8;
  localparam int unsigned HUE_STEP_FAST = 16;
  localparam int unsigned HUE_GAIN = 255;

  // Sine source table size and ramp ROM layout (slow, medium, fast segments)
  localparam int unsigned SINE_ENTRIES = 256;
  localparam longint unsigned SINE_TOP = SINE_ENTRIES - 1;
  localparam int unsigned SINE_ROM_DEPTH = RAMP_SLOW + RAMP_MED + RAMP_FAST + 3;
  localparam int unsigned SINE_IDX_W = $clog2(SINE_ROM_DEPTH);
  localparam int unsigned SINE_W = 16;

  // Serial datapath sizes
  localparam int unsigned MCAND_W = 24;   // base*scale or 255*scale
  localparam int unsigned MUL_W   = 16;   // multiplier, left aligned, 2 bits a step
  localparam int unsigned ACC_W   = 38;   // base*scale*sine
  localparam int unsigned BASE_MUL_STEPS = 4;
  localparam int unsigned HUE_MUL_STEPS  = 5;
  localparam int unsigned SINE_MUL_STEPS = 8;
  localparam int unsigned QUO_W   = 8;
  localparam int unsigned DIV_W   = 33;
  localparam longint unsigned HUE_DIV = HUE_SECTOR * Q15_ONE;
  localparam logic [DIV_W-1:0] HUE_DIV_TOP = DIV_W'(HUE_DIV << (QUO_W - 1));

  // Lane control word
  typedef struct packed {
    logic load;
    logic chain;
    logic step;
  } lane_ctl_t;

  function automatic logic [15:0] scale_q15(input logic [1:0] lvl);
    logic [15:0] s;
    case (lvl)
      LVL_15:  s = SCALE_15;
      LVL_33:  s = SCALE_33;
      LVL_66:  s = SCALE_66;
      default: s = SCALE_100;
    endcase
    return s;
  endfunction

  // 255 * scale, numerator gain of the hue slope
  function automatic logic [MCAND_W-1:0] hue_coef(input logic [1:0] lvl);
    logic [31:0] prod;
    prod = 32'(HUE_GAIN) * 32'(scale_q15(lvl));
    return MCAND_W'(prod);
  endfunction

  // Full channel in hue mode: (255 * scale) >> 15
  function automatic logic [7:0] hue_full(input logic [1:0] lvl);
    logic [31:0] prod;
    prod = 32'(HUE_GAIN) * 32'(scale_q15(lvl));
    return 8'(prod >> 15);
  endfunction

  function automatic logic [7:0] ramp_steps(input logic [1:0] spd);
    logic [7:0] s;
    case (spd)
      SPD_SLOW:   s = 8'(RAMP_SLOW);
      SPD_MEDIUM: s = 8'(RAMP_MED);
      default:    s = 8'(RAMP_FAST);
    endcase
    return s;
  endfunction

  function automatic logic [4:0] hue_step(input logic [1:0] spd);
    logic [4:0] s;
    case (spd)
      SPD_SLOW:   s = 5'(HUE_STEP_SLOW);
      SPD_MEDIUM: s = 5'(HUE_STEP_MED);
      default:    s = 5'(HUE_STEP_FAST);
    endcase
    return s;
  endfunction

  // First ROM entry of each speed's ramp
  function automatic logic [SINE_IDX_W-1:0] rom_base(input logic [1:0] spd);
    logic [SINE_IDX_W-1:0] b;
    case (spd)
      SPD_SLOW:   b = '0;
      SPD_MEDIUM: b = SINE_IDX_W'(RAMP_SLOW + 1);
      default:    b = SINE_IDX_W'(RAMP_SLOW + RAMP_MED + 2);
    endcase
    return b;
  endfunction

  // sin(pi/2 * x), odd degree-7 polynomial, Q1.15 in and out
  function automatic logic [SINE_W-1:0] qsine(input longint unsigned x);
    longint unsigned x2;
    longint unsigned p;
    x2 = (x * x) >> 15;
    p = 64'd2611 - ((64'd153 * x2) >> 15);
    p = 64'd21167 - ((p * x2) >> 15);
    p = 64'd51477 - ((p * x2) >> 15);
    p = (p * x) >> 15;
    if (p > Q15_ONE) p = Q15_ONE;
    return SINE_W'(p);
  endfunction

  // ROM entry j: ramp frame i of its speed segment, mapped onto the sine table
  function automatic logic [SINE_W-1:0] ramp_sine_at(input int unsigned j);
    longint unsigned i;
    longint unsigned k;
    longint unsigned x;
    if (j < RAMP_SLOW + 1) begin
      i = j;
      k = (i * SINE_TOP + RAMP_SLOW / 2) / RAMP_SLOW;
    end else if (j < RAMP_SLOW + RAMP_MED + 2) begin
      i = j - (RAMP_SLOW + 1);
      k = (i * SINE_TOP + RAMP_MED / 2) / RAMP_MED;
    end else begin
      i = j - (RAMP_SLOW + RAMP_MED + 2);
      k = (i * SINE_TOP + RAMP_FAST / 2) / RAMP_FAST;
    end
    if (k > SINE_TOP) k = SINE_TOP;
    x = (k * Q15_ONE) / SINE_TOP;
    return qsine(x);
  endfunction

endpackage

// ===== rtl/core/rgbfx_lane.sv =====
// rgbfx_lane: one color channel of the serial multiplier, two multiplier
// bits per step, MSB first. Depends on rgbfx_pkg (sizes, lane_ctl_t).

module rgbfx_lane (
  input  logic                               clk,
  input  rgbfx_pkg::lane_ctl_t               ctl,
  input  logic [rgbfx_pkg::MCAND_W-1:0]      mcand_in,
  input  logic [rgbfx_pkg::MUL_W-1:0]        mul_in,
  output logic [rgbfx_pkg::ACC_W-1:0]        acc
);

  logic [rgbfx_pkg::MCAND_W-1:0] mcand_r;
  logic [rgbfx_pkg::MUL_W-1:0]   mul_r;
  logic [rgbfx_pkg::ACC_W-1:0]   acc_r;
  logic [rgbfx_pkg::ACC_W-1:0]   acc_nxt;
  logic [rgbfx_pkg::MCAND_W+1:0] part;
  logic [1:0]                    digit;

  // Partial product for the top digit of the multiplier
  always_comb begin
    digit = mul_r[rgbfx_pkg::MUL_W-1 -: 2];
    part  = '0;
    if (digit[0]) part = part + (rgbfx_pkg::MCAND_W+2)'(mcand_r);
    if (digit[1]) part = part + {1'b0, mcand_r, 1'b0};
    acc_nxt = {acc_r[rgbfx_pkg::ACC_W-3:0], 2'b00} + rgbfx_pkg::ACC_W'(part);
  end

  // load starts a product, chain reuses the product as the next multiplicand
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcand_r <= mcand_in;
      mul_r   <= mul_in;
      acc_r   <= '0;
    end else if (ctl.chain) begin
      mcand_r <= acc_r[rgbfx_pkg::MCAND_W-1:0];
      mul_r   <= mul_in;
      acc_r   <= '0;
    end else if (ctl.step) begin
      acc_r <= acc_nxt;
      mul_r <= {mul_r[rgbfx_pkg::MUL_W-3:0], 2'b00};
    end
  end

  assign acc = acc_r;

endmodule

// ===== rtl/core/rgb_led_effect_generator.sv =====
// rgb_led_effect_generator: frame-tick driven RGB effect engine (static,
// breathe, hue cycle, off). Depends on rgbfx_pkg and rgbfx_lane.
//
//  channel | ports                                        | dir
//  --------+----------------------------------------------+--------
//  input   | in_valid, in_stall, in_restart               | in
//  result  | out_valid, out_stall, out_red/green/blue_out | out
//  config  | cfg_wr_en, cfg_index, cfg_data               | in
//
// One word at a time. Off mode and breathe's black hold skip to the final
// state; the rest run the 2-bit-per-step serial multiplier lanes, breathe
// adding a chained sine product and hue cycle the 1-bit-per-step quotient loop of
// the hue slope. Synchronous active-low reset brings the registers to their
// reset values. A stalled result holds in the output register; the next
// word is still taken and waits in the final state.

module rgb_led_effect_generator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_restart,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL1  = 3'd1;
  localparam logic [2:0] ST_CHAIN = 3'd2;
  localparam logic [2:0] ST_MUL2  = 3'd3;
  localparam logic [2:0] ST_DLOAD = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  localparam int unsigned NCH = 3;
  localparam int unsigned SW  = rgbfx_pkg::SINE_IDX_W;

  // Configuration registers
  logic [7:0] base_red_r, base_green_r, base_blue_r;
  logic [1:0] mode_r, speed_r, level_r;

  // Effect state
  logic [7:0] breathe_phase_r;
  logic [2:0] sector_r;
  logic [9:0] frac_r;

  // Per-word working registers
  logic [2:0] st_r, st_nxt;
  logic [2:0] cnt_r;
  logic [6:0] ramp_i_r;
  logic       black_r;
  logic [2:0] word_sector_r;
  logic [rgbfx_pkg::DIV_W-1:0] div_rem_r;
  logic [rgbfx_pkg::DIV_W-1:0] div_d_r;
  logic [rgbfx_pkg::QUO_W-1:0] quo_r;

  // Output register
  logic       out_valid_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r;

  logic in_acc;
  logic out_free;
  logic is_hue;

  // Breathe frame decode
  logic [7:0] phase_eff, steps, two_s1, last_p, phase_next;
  logic       black_eff;
  logic [6:0] ramp_i_eff;

  // Hue walk decode
  logic [2:0] sector_eff, sector_next;
  logic [9:0] frac_eff, frac_sum, frac_next, fx;

  // Sine ramp ROM
  logic [rgbfx_pkg::SINE_W-1:0] sine_rom [rgbfx_pkg::SINE_ROM_DEPTH];
  logic [SW-1:0]                sine_idx;
  logic [rgbfx_pkg::SINE_W-1:0] sine_val;

  // Lanes
  rgbfx_pkg::lane_ctl_t          lane_ctl;
  logic [7:0]                    base_c   [NCH];
  logic [rgbfx_pkg::MCAND_W-1:0] mcand_in [NCH];
  logic [rgbfx_pkg::MUL_W-1:0]   mul_in   [NCH];
  logic [rgbfx_pkg::ACC_W-1:0]   lane_acc [NCH];

  // Result assembly
  logic [7:0] res_r, res_g, res_b, hue_c;
  logic       quo_ge;

  assign in_stall = (st_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign is_hue   = (mode_r == rgbfx_pkg::EFX_CYCLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_red_r   <= rgbfx_pkg::RST_BASE;
      base_green_r <= rgbfx_pkg::RST_BASE;
      base_blue_r  <= rgbfx_pkg::RST_BASE;
      mode_r       <= rgbfx_pkg::EFX_STATIC;
      speed_r      <= rgbfx_pkg::RST_SPEED;
      level_r      <= rgbfx_pkg::RST_BRIGHTNESS;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rgbfx_pkg::REG_BASE_RED:    base_red_r   <= cfg_data;
        rgbfx_pkg::REG_BASE_GREEN:  base_green_r <= cfg_data;
        rgbfx_pkg::REG_BASE_BLUE:   base_blue_r  <= cfg_data;
        rgbfx_pkg::REG_EFFECT_MODE: mode_r       <= cfg_data[1:0];
        rgbfx_pkg::REG_SPEED:       speed_r      <= cfg_data[1:0];
        rgbfx_pkg::REG_BRIGHTNESS:  level_r      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Breathe: ramp up over S+1 frames, down over S+1, then black hold
  always_comb begin
    phase_eff  = in_restart ? 8'd0 : breathe_phase_r;
    steps      = rgbfx_pkg::ramp_steps(speed_r);
    two_s1     = {steps[6:0], 1'b1};
    last_p     = two_s1 + 8'(rgbfx_pkg::HOLD_FRAMES);
    black_eff  = (phase_eff > two_s1);
    ramp_i_eff = (phase_eff <= steps) ? phase_eff[6:0] : 7'(two_s1 - phase_eff);
    phase_next = (phase_eff >= last_p) ? 8'd0 : phase_eff + 8'd1;
  end

  // Hue kept as sector and offset within the sector
  always_comb begin
    sector_eff = in_restart ? 3'd0 : sector_r;
    frac_eff   = in_restart ? 10'd0 : frac_r;
    fx         = sector_eff[0] ? 10'(rgbfx_pkg::HUE_SECTOR) - frac_eff : frac_eff;
    frac_sum   = frac_eff + 10'(rgbfx_pkg::hue_step(speed_r));
    if (frac_sum >= 10'(rgbfx_pkg::HUE_SECTOR)) begin
      frac_next   = frac_sum - 10'(rgbfx_pkg::HUE_SECTOR);
      sector_next = (sector_eff == 3'(rgbfx_pkg::HUE_SECTORS - 1)) ? 3'd0
                                                                   : sector_eff + 3'd1;
    end else begin
      frac_next   = frac_sum;
      sector_next = sector_eff;
    end
  end

  // Effect state advances once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      breathe_phase_r <= '0;
      sector_r        <= '0;
      frac_r          <= '0;
    end else if (in_acc) begin
      breathe_phase_r <= (mode_r == rgbfx_pkg::EFX_BREATHE) ? phase_next : phase_eff;
      sector_r        <= is_hue ? sector_next : sector_eff;
      frac_r          <= is_hue ? frac_next : frac_eff;
    end
  end

  // Ramp ROM contents, computed at elaboration
  for (genvar j = 0; j < rgbfx_pkg::SINE_ROM_DEPTH; j++) begin : g_sine
    localparam logic [rgbfx_pkg::SINE_W-1:0] SV = rgbfx_pkg::ramp_sine_at(j);
    assign sine_rom[j] = SV;
  end

  assign sine_idx = rgbfx_pkg::rom_base(speed_r) + SW'(ramp_i_r);
  assign sine_val = sine_rom[sine_idx];

  // Lane operands
  assign base_c[0] = base_red_r;
  assign base_c[1] = base_green_r;
  assign base_c[2] = base_blue_r;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      mcand_in[c] = rgbfx_pkg::MCAND_W'(rgbfx_pkg::scale_q15(level_r));
      mul_in[c]   = {base_c[c], 8'd0};
      if (st_r == ST_CHAIN) begin
        mul_in[c] = sine_val;
      end else if (is_hue && c == 0) begin
        mcand_in[c] = rgbfx_pkg::hue_coef(level_r);
        mul_in[c]   = {fx, 6'd0};
      end
    end
  end

  assign lane_ctl.load  = in_acc;
  assign lane_ctl.chain = (st_r == ST_CHAIN);
  assign lane_ctl.step  = (st_r == ST_MUL1) || (st_r == ST_MUL2);

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    rgbfx_lane u_lane (
      .clk      (clk),
      .ctl      (lane_ctl),
      .mcand_in (mcand_in[c]),
      .mul_in   (mul_in[c]),
      .acc      (lane_acc[c])
    );
  end

  // Sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (mode_r == rgbfx_pkg::EFX_BLANK ||
              (mode_r == rgbfx_pkg::EFX_BREATHE && black_eff)) begin
            st_nxt = ST_FIN;
          end else begin
            st_nxt = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        if (cnt_r == 3'd0) begin
          if (mode_r == rgbfx_pkg::EFX_BREATHE) st_nxt = ST_CHAIN;
          else if (is_hue)                      st_nxt = ST_DLOAD;
          else                                  st_nxt = ST_FIN;
        end
      end
      ST_CHAIN: st_nxt = ST_MUL2;
      ST_MUL2:  if (cnt_r == 3'd0) st_nxt = ST_FIN;
      ST_DLOAD: st_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == 3'd0) st_nxt = ST_FIN;
      ST_FIN:   if (out_free) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Step counter and per-word latches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= is_hue ? 3'(rgbfx_pkg::HUE_MUL_STEPS - 1) : 3'(rgbfx_pkg::BASE_MUL_STEPS - 1);
    end else if (st_r == ST_CHAIN) begin
      cnt_r <= 3'(rgbfx_pkg::SINE_MUL_STEPS - 1);
    end else if (st_r == ST_DLOAD) begin
      cnt_r <= 3'(rgbfx_pkg::QUO_W - 1);
    end else if (cnt_r != 3'd0) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ramp_i_r      <= ramp_i_eff;
      black_r       <= black_eff;
      word_sector_r <= sector_eff;
    end
  end

  // Hue slope: restoring division by 600*2^15, one quotient bit per step
  assign quo_ge = (div_rem_r >= div_d_r);

  always_ff @(posedge clk) begin
    if (st_r == ST_DLOAD) begin
      div_rem_r <= lane_acc[0][rgbfx_pkg::DIV_W-1:0];
      div_d_r   <= rgbfx_pkg::HUE_DIV_TOP;
      quo_r     <= '0;
    end else if (st_r == ST_DIV) begin
      if (quo_ge) div_rem_r <= div_rem_r - div_d_r;
      div_d_r <= div_d_r >> 1;
      quo_r   <= {quo_r[rgbfx_pkg::QUO_W-2:0], quo_ge};
    end
  end

  // Result word by mode
  always_comb begin
    res_r = 8'd0;
    res_g = 8'd0;
    res_b = 8'd0;
    hue_c = rgbfx_pkg::hue_full(level_r);
    case (mode_r)
      rgbfx_pkg::EFX_STATIC: begin
        res_r = lane_acc[0][22:15];
        res_g = lane_acc[1][22:15];
        res_b = lane_acc[2][22:15];
      end
      rgbfx_pkg::EFX_BREATHE: begin
        if (!black_r) begin
          res_r = lane_acc[0][37:30];
          res_g = lane_acc[1][37:30];
          res_b = lane_acc[2][37:30];
        end
      end
      rgbfx_pkg::EFX_CYCLE: begin
        case (word_sector_r)
          3'd0: begin res_r = hue_c; res_g = quo_r; end
          3'd1: begin res_r = quo_r; res_g = hue_c; end
          3'd2: begin res_g = hue_c; res_b = quo_r; end
          3'd3: begin res_g = quo_r; res_b = hue_c; end
          3'd4: begin res_r = quo_r; res_b = hue_c; end
          default: begin res_r = hue_c; res_b = quo_r; end
        endcase
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_FIN && out_free) begin
      out_red_r   <= res_r;
      out_green_r <= res_g;
      out_blue_r  <= res_b;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_red_r;
  assign out_green_out = out_green_r;
  assign out_blue_out  = out_blue_r;

endmodule
